### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/fcct_pkg.sv
// ---------------------------------------------------------------------------
// fcct_pkg
// Types, codes and defaults of the cluster chain table.
// ---------------------------------------------------------------------------
package fcct_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int ENTRY_WIDTH_DEF = 32;

    localparam int ACTION_W    = 2;
    localparam int CLUSTER_W   = 12;
    localparam int VALUE_W     = 32;
    localparam int LENGTH_W    = 13;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    typedef logic [ACTION_W-1:0]    action_t;
    typedef logic [CLUSTER_W-1:0]   clus_idx_t;
    typedef logic [VALUE_W-1:0]     value_t;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

    localparam action_t ACT_READ   = 2'd0;
    localparam action_t ACT_WRITE  = 2'd1;
    localparam action_t ACT_EXTEND = 2'd2;
    localparam action_t ACT_REMOVE = 2'd3;

    localparam cfg_index_t REG_TABLE_LENGTH = 1'd0;
    localparam cfg_index_t REG_END_MARKER   = 1'd1;

    localparam logic [LENGTH_W-1:0] TABLE_LENGTH_RST = 13'd4096;
    localparam value_t              END_MARKER_RST   = 32'h0FFF_FFFF;

    typedef struct packed {
        action_t   action;
        clus_idx_t cluster;
        value_t    entry_value;
        clus_idx_t prev_cluster;
    } req_t;

    typedef struct packed {
        value_t result_value;
        logic   table_full;
    } res_t;

endpackage

### sv/fcct_in_if.sv
// ---------------------------------------------------------------------------
// fcct_in_if
// Request channel: valid, ready and one request.
// ---------------------------------------------------------------------------
interface fcct_in_if;
    import fcct_pkg::*;

    logic      valid;
    logic      ready;
    action_t   action;
    clus_idx_t cluster;
    value_t    entry_value;
    clus_idx_t prev_cluster;

    modport source (output valid, output action, output cluster, output entry_value,
                    output prev_cluster, input ready);
    modport sink   (input valid, input action, input cluster, input entry_value,
                    input prev_cluster, output ready);
endinterface

### sv/fcct_out_if.sv
// ---------------------------------------------------------------------------
// fcct_out_if
// Result channel: valid, ready and one result.
// ---------------------------------------------------------------------------
interface fcct_out_if;
    import fcct_pkg::*;

    logic   valid;
    logic   ready;
    value_t result_value;
    logic   table_full;

    modport source (output valid, output result_value, output table_full, input ready);
    modport sink   (input valid, input result_value, input table_full, output ready);
endinterface

### sv/fcct_table.sv
// ---------------------------------------------------------------------------
// fcct_table
// Link table memory: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module fcct_table #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/fcct_engine.sv
// ---------------------------------------------------------------------------
// fcct_engine
// Sequencer around the table port and its index compares: clearing pass,
// entry read and write, free-entry scan and chain walk.
// ---------------------------------------------------------------------------
module fcct_engine #(
    parameter int TABLE_DEPTH = fcct_pkg::TABLE_DEPTH_DEF,
    parameter int ENTRY_WIDTH = fcct_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          ready,
    input  fcct_pkg::req_t                req,
    input  logic [fcct_pkg::LENGTH_W-1:0] table_length,
    input  fcct_pkg::value_t              end_marker,
    output logic                          res_valid,
    input  logic                          res_take,
    output fcct_pkg::res_t                res
);
    import fcct_pkg::*;

    localparam int          AW      = $clog2(TABLE_DEPTH);
    localparam int          EW      = ENTRY_WIDTH;
    localparam int          CW      = AW + 1;
    localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_READ    = 4'd2;
    localparam logic [3:0] ST_RDWAIT  = 4'd3;
    localparam logic [3:0] ST_WRITE   = 4'd4;
    localparam logic [3:0] ST_SCAN    = 4'd5;
    localparam logic [3:0] ST_LINK    = 4'd6;
    localparam logic [3:0] ST_MARK    = 4'd7;
    localparam logic [3:0] ST_WALK    = 4'd8;
    localparam logic [3:0] ST_WALKCHK = 4'd9;
    localparam logic [3:0] ST_PREV    = 4'd10;
    localparam logic [3:0] ST_DONE    = 4'd11;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] chk_reg, chk_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [CW-1:0] limit_reg, limit_next;
    logic [31:0]   cur_reg, cur_next;
    clus_idx_t     cluster_reg, cluster_next;
    clus_idx_t     prev_reg, prev_next;
    logic [EW-1:0] value_reg, value_next;
    res_t          res_reg, res_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    logic [EW-1:0] mark;
    logic [31:0]   cluster32;
    logic [31:0]   prev32;
    logic [31:0]   length32;
    logic          cluster_ok;
    logic          prev_ok;
    logic          found;

    assign mark       = end_marker[EW-1:0];
    assign cluster32  = 32'(cluster_reg);
    assign prev32     = 32'(prev_reg);
    assign length32   = 32'(table_length);
    assign cluster_ok = cluster32 < DEPTH32;
    assign prev_ok    = (prev_reg != '0) && (prev32 < DEPTH32);
    assign found      = pend_reg && (mem_rdata == '0);

    assign ready     = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    fcct_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (EW),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        issue_next   = issue_reg;
        pend_next    = pend_reg;
        chk_next     = chk_reg;
        slot_next    = slot_reg;
        limit_next   = limit_reg;
        cur_next     = cur_reg;
        cluster_next = cluster_reg;
        prev_next    = prev_reg;
        value_next   = value_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_raddr    = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                if (clr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cluster_next = req.cluster;
                    prev_next    = req.prev_cluster;
                    value_next   = req.entry_value[EW-1:0];
                    cur_next     = 32'(req.cluster);
                    issue_next   = CW'(1);
                    pend_next    = 1'b0;
                    limit_next   = (length32 < DEPTH32) ? CW'(length32) : CW'(DEPTH32);
                    res_next     = '0;
                    unique case (req.action)
                        ACT_READ:   state_next = ST_READ;
                        ACT_WRITE:  state_next = ST_WRITE;
                        ACT_EXTEND: state_next = ST_SCAN;
                        ACT_REMOVE: state_next = ST_WALK;
                    endcase
                end
            end
            ST_READ:
            begin
                if (cluster_ok)
                begin
                    mem_raddr  = cluster32[AW-1:0];
                    state_next = ST_RDWAIT;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_RDWAIT:
            begin
                res_next.result_value = 32'(mem_rdata);
                state_next            = ST_DONE;
            end
            ST_WRITE:
            begin
                if (cluster_ok)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cluster32[AW-1:0];
                    mem_wdata = value_reg;
                end
                state_next = ST_DONE;
            end
            ST_SCAN:
            begin
                priority if (found)
                begin
                    slot_next  = chk_reg;
                    state_next = ST_LINK;
                end
                else if (issue_reg >= limit_reg)
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        res_next.table_full = 1'b1;
                        state_next          = ST_DONE;
                    end
                end
                else
                begin
                    mem_raddr  = issue_reg[AW-1:0];
                    chk_next   = issue_reg[AW-1:0];
                    pend_next  = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
            end
            ST_LINK:
            begin
                if ((cluster_reg != '0) && cluster_ok)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cluster32[AW-1:0];
                    mem_wdata = EW'(slot_reg);
                end
                state_next = ST_MARK;
            end
            ST_MARK:
            begin
                mem_we                = 1'b1;
                mem_waddr             = slot_reg;
                mem_wdata             = mark;
                res_next.result_value = 32'(slot_reg);
                state_next            = ST_DONE;
            end
            ST_WALK:
            begin
                if (cur_reg < DEPTH32)
                begin
                    mem_raddr  = cur_reg[AW-1:0];
                    state_next = ST_WALKCHK;
                end
                else
                begin
                    state_next = ST_PREV;
                end
            end
            ST_WALKCHK:
            begin
                mem_we    = 1'b1;
                mem_waddr = cur_reg[AW-1:0];
                if ((mem_rdata == mark) || (cur_reg == 32'd1) || (mem_rdata == '0))
                begin
                    state_next = ST_PREV;
                end
                else
                begin
                    cur_next   = 32'(mem_rdata);
                    state_next = ST_WALK;
                end
            end
            ST_PREV:
            begin
                if (prev_ok)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = prev32[AW-1:0];
                    mem_wdata = mark;
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg   <= issue_next;
        chk_reg     <= chk_next;
        slot_reg    <= slot_next;
        limit_reg   <= limit_next;
        cur_reg     <= cur_next;
        cluster_reg <= cluster_next;
        prev_reg    <= prev_next;
        value_reg   <= value_next;
        res_reg     <= res_next;
    end

endmodule

### sv/fat_cluster_chain_table_core.sv
// ---------------------------------------------------------------------------
// fat_cluster_chain_table_core
// Cluster chain table with read, write, extend and remove requests.
// ---------------------------------------------------------------------------
// Usage:
//   in_ch carries one request per transaction (action, cluster, entry_value,
//   prev_cluster); out_ch returns exactly one result per request
//   (result_value, table_full), in request order.
//   cfg_we/cfg_index/cfg_data write table_length and end_marker; write only
//   while no request is in flight.
//   Requests are worked one at a time through the single table port: a read
//   reads the entry and registers the data; a write writes the entry; an extend
//   scans upward from index 1 for a zero entry, one entry a cycle, up to the
//   table_length limit, then links and marks it; a remove walks the chain,
//   clearing each entry visited, then marks a nonzero prev_cluster as the end.
//   in_ch is not ready while a request is in work.
//   After reset a clearing pass writes zero to every entry, with in_ch not
//   ready; configuration writes are taken throughout.
//   A stalled receiver holds the result in the output register; one more
//   request may be accepted and completed, then the block waits for out_ch.
// ---------------------------------------------------------------------------
module fat_cluster_chain_table_core #(
    parameter int TABLE_DEPTH = fcct_pkg::TABLE_DEPTH_DEF,
    parameter int ENTRY_WIDTH = fcct_pkg::ENTRY_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    fcct_in_if.sink                  in_ch,
    fcct_out_if.source               out_ch,
    input  logic                     cfg_we,
    input  fcct_pkg::cfg_index_t     cfg_index,
    input  logic [fcct_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fcct_pkg::*;

    logic [LENGTH_W-1:0] length_reg;
    value_t              marker_reg;
    logic                out_valid_reg;
    res_t                out_res_reg;

    logic eng_ready;
    logic eng_start;
    logic res_valid;
    logic res_take;
    req_t req;
    res_t res;

    assign in_ch.ready = eng_ready;
    assign eng_start   = in_ch.valid && eng_ready;
    assign res_take    = !out_valid_reg || out_ch.ready;

    assign req.action       = in_ch.action;
    assign req.cluster      = in_ch.cluster;
    assign req.entry_value  = in_ch.entry_value;
    assign req.prev_cluster = in_ch.prev_cluster;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_value = out_res_reg.result_value;
    assign out_ch.table_full   = out_res_reg.table_full;

    fcct_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (eng_start),
        .ready        (eng_ready),
        .req          (req),
        .table_length (length_reg),
        .end_marker   (marker_reg),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= TABLE_LENGTH_RST;
            marker_reg <= END_MARKER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TABLE_LENGTH: length_reg <= cfg_data[LENGTH_W-1:0];
                REG_END_MARKER:   marker_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_res_reg <= res;
        end
    end

endmodule

### sv/fcct_checker.sv
// ---------------------------------------------------------------------------
// fcct_checker
// Port-level assertions for the cluster chain table, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fcct_checker (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input fcct_pkg::value_t       result_value,
    input logic                   table_full
);
    import fcct_pkg::*;

    // one request in work at a time
    `ASSERT_NEXT(a_accept_drops_ready, clk, rst_n, in_valid && in_ready, !in_ready)

    // a full table reports no index
    `ASSERT_IMPLY(a_full_zero_value, clk, rst_n, out_valid && table_full, result_value == 32'd0)

    // hold a stalled result
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(result_value) && $stable(table_full))

endmodule

bind fat_cluster_chain_table_core fcct_checker u_fcct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .result_value (out_ch.result_value),
    .table_full   (out_ch.table_full)
);

### tb/sv/chain_table_scoreboard_pkg.sv
// ---------------------------------------------------------------------------
// Cluster chain table scoreboard
// Keeps a private copy of the link table and its two registers. It works out
// the result of every accepted request and checks the results that come
// back, in order, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

package chain_table_scoreboard_pkg;
    import fcct_pkg::*;

    class chain_table_scoreboard;
        value_t                link_entries [TABLE_DEPTH_DEF];
        logic [LENGTH_W-1:0]   table_length;
        value_t                end_marker;
        res_t                  expected_results [$];
        clus_idx_t             recent_slots [$];
        int                    mismatch_count;
        int                    results_checked;
        int                    full_count;
        int                    action_count [4];

        function new();
            foreach (link_entries[i])
                link_entries[i] = '0;
            table_length    = TABLE_LENGTH_RST;
            end_marker      = END_MARKER_RST;
            mismatch_count  = 0;
            results_checked = 0;
            full_count      = 0;
            foreach (action_count[i])
                action_count[i] = 0;
        endfunction

        function void write_config(cfg_index_t index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_TABLE_LENGTH: table_length = data[LENGTH_W-1:0];
                REG_END_MARKER:   end_marker   = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function res_t perform_action(req_t r);
            res_t res;
            int   limit;
            int   slot;
            int   cur;
            value_t link;
            bit   walking;
            res  = '0;
            slot = 0;
            case (r.action)
                ACT_READ:  res.result_value = link_entries[r.cluster];
                ACT_WRITE: link_entries[r.cluster] = r.entry_value;
                ACT_EXTEND:
                begin
                    limit = (table_length > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF
                                                             : int'(table_length);
                    for (int i = 1; i < limit && slot == 0; i++)
                        if (link_entries[i] == '0)
                            slot = i;
                    if (slot != 0)
                    begin
                        if (r.cluster != '0)
                            link_entries[r.cluster] = value_t'(slot);
                        link_entries[slot] = end_marker;
                        res.result_value   = value_t'(slot);
                        recent_slots.push_back(clus_idx_t'(slot));
                        if (recent_slots.size() > 16)
                            void'(recent_slots.pop_front());
                    end
                    else
                    begin
                        res.table_full = 1'b1;
                        full_count++;
                    end
                end
                default:
                begin
                    cur     = int'(r.cluster);
                    walking = 1'b1;
                    while (walking)
                    begin
                        link              = link_entries[cur];
                        link_entries[cur] = '0;
                        if (link == end_marker || cur == 1 || link == '0
                            || link >= TABLE_DEPTH_DEF)
                            walking = 1'b0;
                        else
                            cur = int'(link);
                    end
                    if (r.prev_cluster != '0)
                        link_entries[r.prev_cluster] = end_marker;
                end
            endcase
            return res;
        endfunction

        function void note_request(req_t r);
            action_count[r.action]++;
            expected_results.push_back(perform_action(r));
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            mismatch_count++;
        endtask

        task check_result(value_t got_value, logic got_full);
            res_t want;
            results_checked++;
            if (expected_results.size() == 0)
                report_mismatch($sformatf("result 0x%08h full=%0b with no request pending",
                                          got_value, got_full));
            else
            begin
                want = expected_results.pop_front();
                if (got_value !== want.result_value)
                    report_mismatch($sformatf("result_value 0x%08h, want 0x%08h",
                                              got_value, want.result_value));
                if (got_full !== want.table_full)
                    report_mismatch($sformatf("table_full %0b, want %0b",
                                              got_full, want.table_full));
            end
        endtask
    endclass

endpackage

### tb/sv/fat_cluster_chain_table_core_tb.sv
// ---------------------------------------------------------------------------
// fat_cluster_chain_table_core testbench
// Drives read, write, extend and remove requests through the request
// channel: a directed set of corner cases first, then random phases under
// several table_length and end_marker settings. Both channel ends idle and
// stall at random, and once the result side holds off long enough to back
// the block up. Every result is checked against a private copy of the table.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module fat_cluster_chain_table_core_tb;
    import fcct_pkg::*;
    import chain_table_scoreboard_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 5;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    cfg_index_t            cfg_index = REG_TABLE_LENGTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit sender_idle   = 1'b1;
    bit receiver_idle = 1'b1;
    bit hold_pending  = 1'b0;
    int hold_left     = 0;
    int cycle_count   = 0;

    chain_table_scoreboard sb = new();

    fcct_in_if  in_ch ();
    fcct_out_if out_ch ();

    fat_cluster_chain_table_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("fat_cluster_chain_table_core verification failed");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_left    = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= !(receiver_idle && $urandom_range(0, 99) < 9);
        end
    end

    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_result(out_ch.result_value, out_ch.table_full);

    function automatic req_t make_req(action_t a, clus_idx_t c, value_t v, clus_idx_t p);
        req_t r;
        r.action       = a;
        r.cluster      = c;
        r.entry_value  = v;
        r.prev_cluster = p;
        return r;
    endfunction

    function automatic clus_idx_t pick_cluster(int window);
        if ($urandom_range(0, 99) < 10)
            return clus_idx_t'($urandom);
        return clus_idx_t'($urandom_range(0, window - 1));
    endfunction

    function automatic clus_idx_t pick_recent(int window);
        if (sb.recent_slots.size() == 0)
            return pick_cluster(window);
        return sb.recent_slots[$urandom_range(0, sb.recent_slots.size() - 1)];
    endfunction

    function automatic req_t random_request(int window);
        req_t r;
        int   pick;
        pick           = $urandom_range(0, 99);
        r.action       = (pick < 30) ? ACT_EXTEND :
                         (pick < 50) ? ACT_REMOVE :
                         (pick < 75) ? ACT_READ : ACT_WRITE;
        r.cluster      = pick_cluster(window);
        r.entry_value  = $urandom;
        r.prev_cluster = clus_idx_t'($urandom);
        case (r.action)
            ACT_EXTEND:
                case ($urandom_range(0, 3))
                    0:       r.cluster = '0;
                    1, 2:    r.cluster = pick_recent(window);
                    default: ;
                endcase
            ACT_REMOVE:
            begin
                if ($urandom_range(0, 9) < 6)
                    r.cluster = pick_recent(window);
                case ($urandom_range(0, 3))
                    0, 1:    r.prev_cluster = '0;
                    2:       r.prev_cluster = pick_recent(window);
                    default: r.prev_cluster = pick_cluster(window);
                endcase
            end
            ACT_WRITE:
                case ($urandom_range(0, 5))
                    0:       r.entry_value = '0;
                    1:       r.entry_value = sb.end_marker;
                    2, 3:    r.entry_value = value_t'($urandom_range(1, window - 1));
                    4:       r.entry_value = 32'hFFFF_FFFF;
                    default: ;
                endcase
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_request(req_t r);
        while (sender_idle && $urandom_range(0, 99) < 9)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.action       <= r.action;
        in_ch.cluster      <= r.cluster;
        in_ch.entry_value  <= r.entry_value;
        in_ch.prev_cluster <= r.prev_cluster;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic set_config(logic [LENGTH_W-1:0] length, value_t marker);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TABLE_LENGTH;
        cfg_data  <= CFG_DATA_W'(length);
        @(posedge clk);
        sb.write_config(REG_TABLE_LENGTH, CFG_DATA_W'(length));
        cfg_index <= REG_END_MARKER;
        cfg_data  <= marker;
        @(posedge clk);
        sb.write_config(REG_END_MARKER, marker);
        cfg_we    <= 1'b0;
    endtask

    // drop valid and wait for every outstanding result
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic directed_requests();
        send_request(make_req(ACT_READ,   12'd0,    32'd0,          12'd0));
        send_request(make_req(ACT_READ,   12'd4095, 32'hFFFF_FFFF,  12'd4095));
        send_request(make_req(ACT_WRITE,  12'd4095, 32'hFFFF_FFFF,  12'd0));
        send_request(make_req(ACT_READ,   12'd4095, 32'd0,          12'd0));
        send_request(make_req(ACT_WRITE,  12'd0,    32'h0000_0ABC,  12'd0));
        send_request(make_req(ACT_READ,   12'd0,    32'd0,          12'd0));
        send_request(make_req(ACT_EXTEND, 12'd0,    32'd0,          12'd0));
        send_request(make_req(ACT_EXTEND, 12'd1,    32'd0,          12'd0));
        send_request(make_req(ACT_EXTEND, 12'd3,    32'd0,          12'd0));
        send_request(make_req(ACT_EXTEND, 12'd2,    32'd0,          12'd0));
        send_request(make_req(ACT_READ,   12'd1,    32'd0,          12'd0));
        send_request(make_req(ACT_REMOVE, 12'd1,    32'd0,          12'd0));
        send_request(make_req(ACT_EXTEND, 12'd0,    32'd0,          12'd0));
        send_request(make_req(ACT_REMOVE, 12'd2,    32'd0,          12'd1));
        send_request(make_req(ACT_WRITE,  12'd5,    32'h0001_0000,  12'd0));
        send_request(make_req(ACT_REMOVE, 12'd5,    32'd0,          12'd0));
        send_request(make_req(ACT_WRITE,  12'd6,    32'd7,          12'd0));
        send_request(make_req(ACT_WRITE,  12'd7,    32'd6,          12'd0));
        send_request(make_req(ACT_REMOVE, 12'd6,    32'd0,          12'd4095));
        send_request(make_req(ACT_READ,   12'd7,    32'd0,          12'd0));
        send_request(make_req(ACT_READ,   12'd4095, 32'd0,          12'd0));
        send_request(make_req(ACT_REMOVE, 12'd8,    32'd0,          12'd0));
        send_request(make_req(ACT_WRITE,  12'd4095, 32'd0,          12'd0));
        send_request(make_req(ACT_EXTEND, 12'd4095, 32'd0,          12'd0));
        send_request(make_req(ACT_READ,   12'd4095, 32'd0,          12'd0));
    endtask

    initial
    begin
        int                  phase_items  [PHASES];
        logic [LENGTH_W-1:0] phase_length [PHASES];
        value_t              phase_marker [PHASES];
        bit                  phase_idle   [PHASES];
        int                  window;

        in_ch.valid        = 1'b0;
        in_ch.action       = ACT_READ;
        in_ch.cluster      = '0;
        in_ch.entry_value  = '0;
        in_ch.prev_cluster = '0;

        phase_length = '{13'd4096, 13'd2, 13'd16, 13'd64,
                         LENGTH_W'($urandom_range(2, 300))};
        phase_marker = '{END_MARKER_RST, 32'd1, 32'hFFFF_FFFF, 32'd3, $urandom | 32'd1};
        phase_items  = '{250, 150, 300, 300, 300};
        phase_idle   = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        set_config(13'd4, END_MARKER_RST);
        directed_requests();
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            set_config(phase_length[p], phase_marker[p]);
            sender_idle   = phase_idle[p];
            receiver_idle = phase_idle[p];
            if (p == 1)
                hold_pending = 1'b1;
            window = (phase_length[p] + 4 > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF
                                                             : int'(phase_length[p]) + 4;
            repeat (phase_items[p])
                send_request(random_request(window));
            settle();
        end

        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        $display("requests: %0d read, %0d write, %0d extend (%0d found the table full), %0d remove",
                 sb.action_count[ACT_READ], sb.action_count[ACT_WRITE],
                 sb.action_count[ACT_EXTEND], sb.full_count, sb.action_count[ACT_REMOVE]);
        $display("%0d results checked over %0d register settings, %0d mismatches",
                 sb.results_checked, PHASES + 1, sb.mismatch_count);
        if (sb.mismatch_count == 0)
            $display("fat_cluster_chain_table_core verification clean");
        else
            $display("fat_cluster_chain_table_core verification failed");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/fcct_pkg.sv
sv/fcct_in_if.sv
sv/fcct_out_if.sv
sv/fcct_table.sv
sv/fcct_engine.sv
sv/fat_cluster_chain_table_core.sv
sv/fcct_checker.sv
tb/sv/chain_table_scoreboard_pkg.sv
tb/sv/fat_cluster_chain_table_core_tb.sv
